[hw/rtl/dbmidi_pkg.sv]
// Types and constants for the debounced button to MIDI event block.
`timescale 1ns / 1ps

package dbmidi_pkg;

	localparam int NOW_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam logic [1:0] CMD_SAMPLE      = 2'd0;
	localparam logic [1:0] CMD_SET_CHANNEL = 2'd1;
	localparam logic [1:0] CMD_SET_ADDRESS = 2'd2;

	localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [1:0] KIND_CC       = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INVERT_INPUT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACKS_PER_BANK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_CHANNEL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_TYPE    = 3'd6;

	typedef struct packed {
		logic [1:0]       command;
		logic             pin_level;
		logic [NOW_W-1:0] now_ms;
		logic [7:0]       offset_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] message_kind;
		logic [7:0] midi_channel;
		logic [7:0] note_or_controller;
		logic [6:0] data_value;
	} out_item_t;

endpackage

[hw/rtl/debounced_button_midi_event.sv]
// Top level: debounces one button and turns its edges into MIDI event items.
// Datapath: an accepted item is registered in the input register, then its result is
//   registered in the result register.
// Throughput: one item per cycle; the input register advances whenever the result
//   register is empty or being taken.
// Reset: arst_n asynchronously resets all but the item and result data registers.
`timescale 1ns / 1ps

module debounced_button_midi_event #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  dbmidi_pkg::in_item_t                  in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output dbmidi_pkg::out_item_t                 out_data,
	input  logic                                  cfg_we,
	input  logic [dbmidi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbmidi_pkg::CFG_W-1:0]          cfg_data
);

	logic        invert_q;
	logic [15:0] debounce_q;
	logic [7:0]  tracks_q;
	logic [7:0]  base_ch_q;
	logic [7:0]  base_addr_q;
	logic [6:0]  velocity_q;
	logic        msg_type_q;

	logic                  deb_level_q;
	logic                  last_raw_q;
	logic [TIME_WIDTH-1:0] last_change_q;
	logic [7:0]            act_ch_q;
	logic [7:0]            act_addr_q;
	logic [7:0]            pend_ch_q;
	logic [7:0]            pend_addr_q;

	logic                  valid_s1;
	dbmidi_pkg::in_item_t  item_s1;
	logic                  advance;

	logic                  level;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  quiet;
	logic                  is_sample;
	logic                  press;
	logic                  release_evt;
	logic [7:0]            ch_prod;
	logic [7:0]            addr_prod;
	dbmidi_pkg::out_item_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q    <= 1'b0;
			debounce_q  <= 16'd25;
			tracks_q    <= 8'd1;
			base_ch_q   <= 8'd1;
			base_addr_q <= 8'd0;
			velocity_q  <= 7'd127;
			msg_type_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dbmidi_pkg::REG_INVERT_INPUT:    invert_q    <= cfg_data[0];
				dbmidi_pkg::REG_DEBOUNCE_MS:     debounce_q  <= cfg_data[15:0];
				dbmidi_pkg::REG_TRACKS_PER_BANK: tracks_q    <= cfg_data[7:0];
				dbmidi_pkg::REG_BASE_CHANNEL:    base_ch_q   <= cfg_data[7:0];
				dbmidi_pkg::REG_BASE_ADDRESS:    base_addr_q <= cfg_data[7:0];
				dbmidi_pkg::REG_VELOCITY:        velocity_q  <= cfg_data[6:0];
				dbmidi_pkg::REG_MESSAGE_TYPE:    msg_type_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		level       = item_s1.pin_level ^ invert_q;
		now_t       = TIME_WIDTH'(item_s1.now_ms);
		elapsed     = now_t - last_change_q;
		quiet       = elapsed > TIME_WIDTH'(debounce_q);
		is_sample   = item_s1.command == dbmidi_pkg::CMD_SAMPLE;
		press       = is_sample && quiet && !level && deb_level_q;
		release_evt = is_sample && quiet && level && !deb_level_q;
		ch_prod     = act_ch_q * tracks_q;
		addr_prod   = act_addr_q * tracks_q;

		result.midi_channel       = base_ch_q + ch_prod;
		result.note_or_controller = base_addr_q + addr_prod;
		if (msg_type_q) begin
			result.message_kind = dbmidi_pkg::KIND_CC;
			result.data_value   = press ? velocity_q : 7'd0;
		end else begin
			result.message_kind = press ? dbmidi_pkg::KIND_NOTE_ON : dbmidi_pkg::KIND_NOTE_OFF;
			result.data_value   = velocity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_level_q   <= 1'b1;
			last_raw_q    <= 1'b1;
			last_change_q <= '0;
			act_ch_q      <= 8'd0;
			act_addr_q    <= 8'd0;
			pend_ch_q     <= 8'd0;
			pend_addr_q   <= 8'd0;
		end else if (advance) begin
			unique case (item_s1.command)
				dbmidi_pkg::CMD_SET_CHANNEL: begin
					if (deb_level_q) begin
						act_ch_q <= item_s1.offset_value;
					end
					pend_ch_q <= item_s1.offset_value;
				end
				dbmidi_pkg::CMD_SET_ADDRESS: begin
					if (deb_level_q) begin
						act_addr_q <= item_s1.offset_value;
					end
					pend_addr_q <= item_s1.offset_value;
				end
				dbmidi_pkg::CMD_SAMPLE: begin
					if (press) begin
						deb_level_q <= 1'b0;
					end else if (release_evt) begin
						deb_level_q <= 1'b1;
						act_ch_q    <= pend_ch_q;
						act_addr_q  <= pend_addr_q;
					end
					if (level != last_raw_q) begin
						last_change_q <= now_t;
						last_raw_q    <= level;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= press || release_evt;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (press || release_evt)) begin
			out_data <= result;
		end
	end

endmodule

[hw/rtl/dbmidi_checker.sv]
// Port-level checker for the debounced button to MIDI event block, with its bind.
`timescale 1ns / 1ps

module dbmidi_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input dbmidi_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.message_kind == dbmidi_pkg::KIND_NOTE_ON ||
			out_data.message_kind == dbmidi_pkg::KIND_NOTE_OFF ||
			out_data.message_kind == dbmidi_pkg::KIND_CC))
		else $error("illegal message kind");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_ready_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while result taken");

endmodule

bind debounced_button_midi_event dbmidi_checker u_dbmidi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[bench/tb_debounced_button_midi_event.sv]
// Self-checking bench for the debounced button to MIDI event block.
`timescale 1ns / 1ps

module tb_debounced_button_midi_event;

	localparam logic [1:0]                      CMD_UNUSED = 2'd3;
	localparam logic [dbmidi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int SETTLE      = 8;
	localparam int QUIET_LIMIT = 3000;

	class midi_event_board;
		logic        invert;
		logic [15:0] debounce;
		logic [7:0]  tracks;
		logic [7:0]  base_ch;
		logic [7:0]  base_addr;
		logic [6:0]  vel;
		logic        cc_mode;
		logic        settled_level;
		logic        raw_level;
		logic [31:0] change_ms;
		logic [7:0]  ch_ofs;
		logic [7:0]  addr_ofs;
		logic [7:0]  ch_ofs_next;
		logic [7:0]  addr_ofs_next;
		dbmidi_pkg::out_item_t events_due[$];
		int          errors;
		int          reports;
		int          events_seen;

		function new();
			invert = 1'b0;
			debounce = 16'd25;
			tracks = 8'd1;
			base_ch = 8'd1;
			base_addr = 8'd0;
			vel = 7'd127;
			cc_mode = 1'b0;
			settled_level = 1'b1;
			raw_level = 1'b1;
			change_ms = '0;
			ch_ofs = '0;
			addr_ofs = '0;
			ch_ofs_next = '0;
			addr_ofs_next = '0;
			errors = 0;
			reports = 0;
			events_seen = 0;
		endfunction

		function void write_reg(logic [dbmidi_pkg::CFG_IDX_W-1:0] idx,
				logic [dbmidi_pkg::CFG_W-1:0] val);
			case (idx)
				dbmidi_pkg::REG_INVERT_INPUT: invert = val[0];
				dbmidi_pkg::REG_DEBOUNCE_MS: debounce = val[15:0];
				dbmidi_pkg::REG_TRACKS_PER_BANK: tracks = val[7:0];
				dbmidi_pkg::REG_BASE_CHANNEL: base_ch = val[7:0];
				dbmidi_pkg::REG_BASE_ADDRESS: base_addr = val[7:0];
				dbmidi_pkg::REG_VELOCITY: vel = val[6:0];
				dbmidi_pkg::REG_MESSAGE_TYPE: cc_mode = val[0];
				default: ;
			endcase
		endfunction

		function dbmidi_pkg::out_item_t compute_event(logic [1:0] kind, logic [6:0] data);
			dbmidi_pkg::out_item_t ev;
			logic [7:0] ch;
			logic [7:0] ad;
			ch = base_ch + ch_ofs * tracks;
			ad = base_addr + addr_ofs * tracks;
			ev.message_kind = kind;
			ev.midi_channel = ch;
			ev.note_or_controller = ad;
			ev.data_value = data;
			return ev;
		endfunction

		function void take_item(dbmidi_pkg::in_item_t it);
			logic        lvl;
			logic [31:0] elapsed;
			case (it.command)
				dbmidi_pkg::CMD_SET_CHANNEL: begin
					if (settled_level)
						ch_ofs = it.offset_value;
					ch_ofs_next = it.offset_value;
				end
				dbmidi_pkg::CMD_SET_ADDRESS: begin
					if (settled_level)
						addr_ofs = it.offset_value;
					addr_ofs_next = it.offset_value;
				end
				dbmidi_pkg::CMD_SAMPLE: begin
					lvl = it.pin_level ^ invert;
					elapsed = it.now_ms - change_ms;
					if (elapsed > {16'd0, debounce}) begin
						if (!lvl && settled_level) begin
							settled_level = 1'b0;
							events_due.push_back(compute_event(
								cc_mode ? dbmidi_pkg::KIND_CC : dbmidi_pkg::KIND_NOTE_ON, vel));
						end else if (lvl && !settled_level) begin
							settled_level = 1'b1;
							events_due.push_back(compute_event(
								cc_mode ? dbmidi_pkg::KIND_CC : dbmidi_pkg::KIND_NOTE_OFF,
								cc_mode ? 7'd0 : vel));
							ch_ofs = ch_ofs_next;
							addr_ofs = addr_ofs_next;
						end
					end
					if (lvl != raw_level) begin
						change_ms = it.now_ms;
						raw_level = lvl;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_event(dbmidi_pkg::out_item_t got);
			dbmidi_pkg::out_item_t want;
			if (events_due.size() == 0) begin
				errors++;
				if (reports < 10) begin
					reports++;
					$display("mismatch: unexpected event kind=%0d ch=%0d addr=%0d data=%0d",
						got.message_kind, got.midi_channel, got.note_or_controller,
						got.data_value);
				end
				return;
			end
			want = events_due.pop_front();
			events_seen++;
			if (got.message_kind !== want.message_kind
					|| got.midi_channel !== want.midi_channel
					|| got.note_or_controller !== want.note_or_controller
					|| got.data_value !== want.data_value) begin
				errors++;
				if (reports < 10) begin
					reports++;
					$display("mismatch at event %0d: expected kind=%0d ch=%0d addr=%0d data=%0d",
						events_seen, want.message_kind, want.midi_channel,
						want.note_or_controller, want.data_value);
					$display("    actual kind=%0d ch=%0d addr=%0d data=%0d",
						got.message_kind, got.midi_channel, got.note_or_controller,
						got.data_value);
				end
			end
		endfunction

		function void close_out();
			if (events_due.size() != 0) begin
				errors += events_due.size();
				$display("mismatch: %0d expected events never arrived", events_due.size());
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	dbmidi_pkg::in_item_t             in_data = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	dbmidi_pkg::out_item_t            out_data;
	logic                             cfg_we = 1'b0;
	logic [dbmidi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dbmidi_pkg::CFG_W-1:0]     cfg_data = '0;

	midi_event_board sb = new();
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          items_sent = 0;
	int          quiet = 0;
	logic [31:0] clock_ms = '0;

	debounced_button_midi_event i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_event(out_data);
			if (in_valid && in_ready)
				sb.take_item(in_data);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic send_item(logic [1:0] cmd, logic pin, logic [31:0] now, logic [7:0] ofs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.command = cmd;
		in_data.pin_level = pin;
		in_data.now_ms = now;
		in_data.offset_value = ofs;
		do @(posedge clk); while (!in_ready);
		if (cmd != CMD_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic sample(logic pin, int unsigned gap);
		clock_ms = clock_ms + gap;
		send_item(dbmidi_pkg::CMD_SAMPLE, pin, clock_ms, 8'($urandom));
	endtask

	task automatic sample_at(logic pin, logic [31:0] t);
		clock_ms = t;
		send_item(dbmidi_pkg::CMD_SAMPLE, pin, clock_ms, 8'($urandom));
	endtask

	task automatic wait_all_events();
		in_valid = 1'b0;
		while (sb.events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(logic [dbmidi_pkg::CFG_IDX_W-1:0] idx,
			logic [dbmidi_pkg::CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_phase(int p);
		logic [dbmidi_pkg::CFG_W-1:0] junk;
		junk = 16'($urandom);
		case (p)
			0: begin
				cfg_write(dbmidi_pkg::REG_INVERT_INPUT, {junk[15:1], 1'b0});
				cfg_write(dbmidi_pkg::REG_DEBOUNCE_MS, 16'd25);
				cfg_write(dbmidi_pkg::REG_TRACKS_PER_BANK, {junk[15:8], 8'd1});
				cfg_write(dbmidi_pkg::REG_BASE_CHANNEL, 16'd1);
				cfg_write(dbmidi_pkg::REG_BASE_ADDRESS, 16'd0);
				cfg_write(dbmidi_pkg::REG_VELOCITY, 16'd127);
				cfg_write(dbmidi_pkg::REG_MESSAGE_TYPE, 16'd0);
			end
			1: begin
				cfg_write(dbmidi_pkg::REG_INVERT_INPUT, 16'd0);
				cfg_write(dbmidi_pkg::REG_DEBOUNCE_MS, 16'd0);
				cfg_write(dbmidi_pkg::REG_TRACKS_PER_BANK, 16'd0);
				cfg_write(dbmidi_pkg::REG_BASE_CHANNEL, 16'd0);
				cfg_write(dbmidi_pkg::REG_BASE_ADDRESS, 16'd0);
				cfg_write(dbmidi_pkg::REG_VELOCITY, {junk[15:7], 7'd0});
				cfg_write(dbmidi_pkg::REG_MESSAGE_TYPE, 16'd1);
			end
			2: begin
				cfg_write(dbmidi_pkg::REG_INVERT_INPUT, 16'd1);
				cfg_write(dbmidi_pkg::REG_DEBOUNCE_MS, 16'hFFFF);
				cfg_write(dbmidi_pkg::REG_TRACKS_PER_BANK, 16'd255);
				cfg_write(dbmidi_pkg::REG_BASE_CHANNEL, 16'd255);
				cfg_write(dbmidi_pkg::REG_BASE_ADDRESS, 16'd255);
				cfg_write(dbmidi_pkg::REG_VELOCITY, 16'd127);
				cfg_write(dbmidi_pkg::REG_MESSAGE_TYPE, 16'd0);
				cfg_write(REG_UNUSED, junk);
			end
			3: begin
				cfg_write(dbmidi_pkg::REG_INVERT_INPUT, 16'd1);
				cfg_write(dbmidi_pkg::REG_DEBOUNCE_MS, 16'(32'($urandom_range(0, 40))));
				cfg_write(dbmidi_pkg::REG_TRACKS_PER_BANK, 16'($urandom));
				cfg_write(dbmidi_pkg::REG_MESSAGE_TYPE, 16'd1);
			end
			default: begin
				cfg_write(dbmidi_pkg::REG_INVERT_INPUT, 16'($urandom));
				cfg_write(dbmidi_pkg::REG_DEBOUNCE_MS, 16'(($urandom_range(7) == 0) ? $urandom
					: $urandom_range(0, 300)));
				cfg_write(dbmidi_pkg::REG_TRACKS_PER_BANK, 16'($urandom));
				cfg_write(dbmidi_pkg::REG_BASE_CHANNEL, 16'($urandom));
				cfg_write(dbmidi_pkg::REG_BASE_ADDRESS, 16'($urandom));
				cfg_write(dbmidi_pkg::REG_VELOCITY, 16'($urandom));
				cfg_write(dbmidi_pkg::REG_MESSAGE_TYPE, 16'($urandom));
			end
		endcase
		cfg_we = 1'b0;
	endtask

	task automatic settle_on(logic pin);
		int unsigned d;
		d = {16'd0, sb.debounce};
		if ($urandom_range(7) == 0) begin
			sample(pin, d);
			sample(pin, 1);
		end else begin
			sample(pin, d + 1 + $urandom_range(0, 5));
		end
	endtask

	task automatic bounce_to(logic pin);
		int n;
		n = $urandom_range(0, 3);
		repeat (n) begin
			sample(pin, $urandom_range(0, sb.debounce));
			sample(~pin, $urandom_range(0, sb.debounce));
		end
		sample(pin, $urandom_range(0, sb.debounce));
		settle_on(pin);
	endtask

	task automatic offset_burst();
		repeat ($urandom_range(1, 2))
			send_item($urandom_range(0, 1) ? dbmidi_pkg::CMD_SET_CHANNEL
				: dbmidi_pkg::CMD_SET_ADDRESS, 1'($urandom), $urandom, 8'($urandom));
	endtask

	task automatic button_cycle();
		logic down;
		down = sb.invert;
		if ($urandom_range(3) == 0)
			offset_burst();
		bounce_to(down);
		if ($urandom_range(2) == 0)
			offset_burst();
		bounce_to(~down);
	endtask

	task automatic noise_item();
		logic [1:0] cmd;
		cmd = 2'($urandom_range(0, 3));
		if (cmd == dbmidi_pkg::CMD_SAMPLE) begin
			if ($urandom_range(7) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, 2 * sb.debounce + 2);
			send_item(cmd, 1'($urandom), clock_ms, 8'($urandom));
		end else begin
			send_item(cmd, 1'($urandom), $urandom, 8'($urandom));
		end
	endtask

	initial begin
		int target;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		cfg_write(REG_UNUSED, 16'($urandom));
		cfg_we = 1'b0;
		sample_at(1'b1, 32'd0);
		send_item(CMD_UNUSED, 1'($urandom), $urandom, 8'($urandom));
		send_item(dbmidi_pkg::CMD_SET_CHANNEL, 1'b1, 32'd0, 8'd255);
		send_item(dbmidi_pkg::CMD_SET_ADDRESS, 1'b0, 32'hFFFF_FFFF, 8'd255);
		sample_at(1'b0, 32'd100);
		send_item(dbmidi_pkg::CMD_SET_CHANNEL, 1'b0, 32'd0, 8'd3);
		send_item(dbmidi_pkg::CMD_SET_ADDRESS, 1'b1, 32'd0, 8'd7);
		sample_at(1'b1, 32'd110);
		sample_at(1'b1, 32'd135);
		sample_at(1'b1, 32'd136);
		sample_at(1'b0, 32'hFFFF_FFF0);
		sample_at(1'b1, 32'hFFFF_FFFF);
		sample_at(1'b1, 32'h0000_001A);
		sample_at(1'b0, 32'h0000_0020);
		sample_at(1'b1, 32'h0000_0021);
		sample_at(1'b1, 32'h0000_0040);
		sample_at(1'b0, 32'h5555_AAAA);
		sample_at(1'b1, 32'hAAAA_5555);
		wait_all_events();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_phase(p);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 83; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 83; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			if (p == 2)
				clock_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(99) < 80)
					button_cycle();
				else
					repeat ($urandom_range(1, 3)) noise_item();
				if ($urandom_range(49) == 0)
					wait_all_events();
			end
			wait_all_events();
		end

		idle_pct = 0;
		stall_pct = 0;
		repeat (SETTLE) @(negedge clk);
		sb.close_out();
		$display("Checked %0d MIDI events from %0d sample and offset items", sb.events_seen,
			items_sent);
		$display("across %0d register settings with zero and full-scale debounce and banks",
			NUM_PHASES);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
hw/rtl/dbmidi_pkg.sv
hw/rtl/debounced_button_midi_event.sv
hw/rtl/dbmidi_checker.sv
bench/tb_debounced_button_midi_event.sv
